/* rtl/core/crs_pkg.sv */
// Shared types, widths and sequencer phase codes of the Catmull-Rom spline sampler.
// No dependencies; every other file of the sampler depends on this package.
package crs_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int STEP_WIDTH  = 16;
   localparam int COEF_WIDTH  = COORD_WIDTH + 4;
   localparam int ACC_WIDTH   = COORD_WIDTH + 6;
   localparam int PROD_WIDTH  = ACC_WIDTH + STEP_WIDTH + 1;
   localparam int FIN_WIDTH   = PROD_WIDTH + 1;
   localparam int PHASE_WIDTH = 3;

   localparam logic [STEP_WIDTH-1:0] MIN_STEP     = STEP_WIDTH'(1024);
   localparam logic [STEP_WIDTH-1:0] T_STEP_RESET = STEP_WIDTH'(1311);

   // Horner phases of one sample, x and y interleaved on the shared multiplier
   localparam logic [PHASE_WIDTH-1:0] PH_DX  = 3'd0;
   localparam logic [PHASE_WIDTH-1:0] PH_DY  = 3'd1;
   localparam logic [PHASE_WIDTH-1:0] PH_UX  = 3'd2;
   localparam logic [PHASE_WIDTH-1:0] PH_UY  = 3'd3;
   localparam logic [PHASE_WIDTH-1:0] PH_VX  = 3'd4;
   localparam logic [PHASE_WIDTH-1:0] PH_VY  = 3'd5;
   localparam logic [PHASE_WIDTH-1:0] PH_OUT = 3'd6;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [COEF_WIDTH-1:0]  coef_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef struct packed {
      coef_type a;
      coef_type b;
      coef_type c;
      coef_type d;
   } poly_type;

   typedef struct packed {
      logic                   load;
      logic                   run;
      logic [PHASE_WIDTH-1:0] phase;
   } ctl_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      sat;
   } result_type;

endpackage

/* rtl/core/crs_req_if.sv */
// Control point request channel: valid/ready plus point coordinates and restart flag.
// Depends on crs_pkg for the coordinate width.
interface crs_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [crs_pkg::COORD_WIDTH-1:0] point_x;
   logic signed [crs_pkg::COORD_WIDTH-1:0] point_y;
   logic                                 restart;

   modport source (output valid, point_x, point_y, restart, input ready);
   modport sink   (input valid, point_x, point_y, restart, output ready);
endinterface

/* rtl/core/crs_rsp_if.sv */
// Sample response channel: valid/ready plus sample coordinates and flags.
// Depends on crs_pkg for the coordinate width.
interface crs_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [crs_pkg::COORD_WIDTH-1:0] sample_x;
   logic signed [crs_pkg::COORD_WIDTH-1:0] sample_y;
   logic                                 last_of_segment;
   logic                                 saturated;

   modport source (output valid, sample_x, sample_y, last_of_segment, saturated, input ready);
   modport sink   (input valid, sample_x, sample_y, last_of_segment, saturated, output ready);
endinterface

/* rtl/core/crs_csr_if.sv */
// Configuration write channel carrying the t_step register value.
// Depends on crs_pkg for the step width.
interface crs_csr_if;
   logic                             valid;
   logic                             ready;
   logic [crs_pkg::STEP_WIDTH-1:0]   t_step;

   modport source (output valid, t_step, input ready);
   modport sink   (input valid, t_step, output ready);
endinterface

/* rtl/core/crs_window.sv */
// Three-point history window, fill count and per-segment polynomial coefficient registers.
// Depends on crs_pkg.
module crs_window (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  crs_pkg::point_type point,
   input  logic               restart,
   input  crs_pkg::ctl_type   ctl,
   output logic               full,
   output crs_pkg::poly_type  poly_x,
   output crs_pkg::poly_type  poly_y
);
   import crs_pkg::*;

   point_type  win_ff [0:2];
   point_type  p3_ff;
   logic [1:0] held_ff;
   logic [1:0] held_in;
   poly_type   poly_x_ff;
   poly_type   poly_y_ff;

   function automatic poly_type make_poly(coord_type p0, coord_type p1,
                                          coord_type p2, coord_type p3);
      coef_type e0;
      coef_type e1;
      coef_type e2;
      coef_type e3;
      poly_type r;
      e0 = COEF_WIDTH'(p0);
      e1 = COEF_WIDTH'(p1);
      e2 = COEF_WIDTH'(p2);
      e3 = COEF_WIDTH'(p3);
      r.a = e1 <<< 1;
      r.b = e2 - e0;
      r.c = (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
      r.d = e1 + (e1 <<< 1) - e2 - (e2 <<< 1) + e3 - e0;
      return r;
   endfunction

   assign full = (held_ff == 2'd3);

   always_comb begin
      held_in = held_ff;
      if (accept) begin
         if (restart) begin
            held_in = 2'd1;
         end else if (!full) begin
            held_in = held_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 2'd0;
      end else begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (restart) begin
            win_ff[0] <= point;
         end else if (!full) begin
            win_ff[held_ff] <= point;
         end else begin
            p3_ff <= point;
         end
      end else if (ctl.load) begin
         // capture coefficients from the old window, then advance it
         poly_x_ff <= make_poly(win_ff[0].x, win_ff[1].x, win_ff[2].x, p3_ff.x);
         poly_y_ff <= make_poly(win_ff[0].y, win_ff[1].y, win_ff[2].y, p3_ff.y);
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= p3_ff;
      end
   end

   assign poly_x = poly_x_ff;
   assign poly_y = poly_y_ff;

endmodule

/* rtl/core/crs_datapath.sv */
// Shared multiply unit with Horner accumulators, rounding and coordinate clipping.
// Depends on crs_pkg; driven phase by phase by crs_seq.
module crs_datapath (
   input  logic                           clock,
   input  crs_pkg::ctl_type               ctl,
   input  logic [crs_pkg::STEP_WIDTH-1:0] t,
   input  crs_pkg::poly_type              poly_x,
   input  crs_pkg::poly_type              poly_y,
   output crs_pkg::result_type            result
);
   import crs_pkg::*;

   localparam logic signed [PROD_WIDTH-1:0] RND_U =
      PROD_WIDTH'(64'sd1 <<< (STEP_WIDTH - 1));
   localparam logic signed [FIN_WIDTH-1:0] RND_F =
      FIN_WIDTH'(64'sd1 <<< STEP_WIDTH);
   localparam logic signed [FIN_WIDTH-1:0] COORD_HI =
      FIN_WIDTH'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
   localparam logic signed [FIN_WIDTH-1:0] COORD_LO = -COORD_HI - FIN_WIDTH'(1);

   logic signed [ACC_WIDTH-1:0]    mul_opnd;
   logic signed [STEP_WIDTH:0]     mul_t;
   logic signed [PROD_WIDTH-1:0]   prod_in;
   logic signed [PROD_WIDTH-1:0]   prod_ff;
   logic signed [PROD_WIDTH-1:0]   rnd_u;
   coef_type                       add_coef;
   coef_type                       fin_coef;
   logic signed [ACC_WIDTH-1:0]    acc_in;
   logic signed [ACC_WIDTH-1:0]    accx_ff;
   logic signed [ACC_WIDTH-1:0]    accy_ff;
   logic signed [FIN_WIDTH-1:0]    fin_sum;
   logic signed [FIN_WIDTH-1:0]    fin_q;
   coord_type                      clip_val;
   logic                           clip_sat;
   coord_type                      sx_ff;
   logic                           satx_ff;

   always_comb begin
      mul_opnd = accx_ff;
      add_coef = poly_x.c;
      fin_coef = poly_x.a;
      unique case (ctl.phase)
         PH_DX: begin
            mul_opnd = ACC_WIDTH'(poly_x.d);
         end
         PH_DY: begin
            mul_opnd = ACC_WIDTH'(poly_y.d);
            add_coef = poly_x.c;
         end
         PH_UX: begin
            mul_opnd = accx_ff;
            add_coef = poly_y.c;
         end
         PH_UY: begin
            mul_opnd = accy_ff;
            add_coef = poly_x.b;
         end
         PH_VX: begin
            mul_opnd = accx_ff;
            add_coef = poly_y.b;
         end
         PH_VY: begin
            mul_opnd = accy_ff;
            fin_coef = poly_x.a;
         end
         PH_OUT: begin
            fin_coef = poly_y.a;
         end
         default: begin
            mul_opnd = accx_ff;
         end
      endcase
   end

   assign mul_t   = signed'({1'b0, t});
   assign prod_in = mul_opnd * mul_t;
   assign rnd_u   = (prod_ff + RND_U) >>> STEP_WIDTH;
   assign acc_in  = ACC_WIDTH'(rnd_u) + ACC_WIDTH'(add_coef);
   assign fin_sum = FIN_WIDTH'(prod_ff) + (FIN_WIDTH'(fin_coef) <<< STEP_WIDTH) + RND_F;
   assign fin_q   = fin_sum >>> (STEP_WIDTH + 1);

   always_comb begin
      clip_sat = 1'b0;
      clip_val = COORD_WIDTH'(fin_q);
      if (fin_q > COORD_HI) begin
         clip_sat = 1'b1;
         clip_val = COORD_WIDTH'(COORD_HI);
      end else if (fin_q < COORD_LO) begin
         clip_sat = 1'b1;
         clip_val = COORD_WIDTH'(COORD_LO);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.run) begin
         if (ctl.phase != PH_OUT) begin
            prod_ff <= prod_in;
         end
         if (ctl.phase == PH_DY || ctl.phase == PH_UY) begin
            accx_ff <= acc_in;
         end
         if (ctl.phase == PH_UX || ctl.phase == PH_VX) begin
            accy_ff <= acc_in;
         end
         if (ctl.phase == PH_VY) begin
            sx_ff   <= clip_val;
            satx_ff <= clip_sat;
         end
      end
   end

   assign result.x   = sx_ff;
   assign result.y   = clip_val;
   assign result.sat = satx_ff | clip_sat;

endmodule

/* rtl/core/crs_seq.sv */
// Segment sequencer: steps t through the segment and walks the Horner phases.
// Depends on crs_pkg.
module crs_seq (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           rsp_free,
   input  logic [crs_pkg::STEP_WIDTH-1:0] t_step,
   output crs_pkg::ctl_type               ctl,
   output logic [crs_pkg::STEP_WIDTH-1:0] t,
   output logic                           emit,
   output logic                           last,
   output logic                           idle
);
   import crs_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_CALC = 2'd2;

   logic [1:0]             state_ff;
   logic [1:0]             state_in;
   logic [PHASE_WIDTH-1:0] phase_ff;
   logic [PHASE_WIDTH-1:0] phase_in;
   logic [STEP_WIDTH-1:0]  t_ff;
   logic [STEP_WIDTH-1:0]  t_in;
   logic [STEP_WIDTH-1:0]  step_ff;
   logic [STEP_WIDTH-1:0]  step_in;
   logic [STEP_WIDTH:0]    t_sum;

   assign t_sum = {1'b0, t_ff} + {1'b0, step_ff};

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      t_in     = t_ff;
      step_in  = step_ff;
      emit     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_LOAD;
               phase_in = PH_DX;
               t_in     = '0;
               step_in  = (t_step < MIN_STEP) ? MIN_STEP : t_step;
            end
         end
         ST_LOAD: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            if (phase_ff == PH_OUT) begin
               // hold until the response register frees
               if (rsp_free) begin
                  emit     = 1'b1;
                  phase_in = PH_DX;
                  t_in     = t_sum[STEP_WIDTH-1:0];
                  if (t_sum[STEP_WIDTH]) begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               phase_in = phase_ff + PHASE_WIDTH'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_DX;
         t_ff     <= '0;
         step_ff  <= MIN_STEP;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         t_ff     <= t_in;
         step_ff  <= step_in;
      end
   end

   assign ctl.load  = (state_ff == ST_LOAD);
   assign ctl.run   = (state_ff == ST_CALC);
   assign ctl.phase = phase_ff;
   assign t         = t_ff;
   assign last      = t_sum[STEP_WIDTH];
   assign idle      = (state_ff == ST_IDLE);

endmodule

/* rtl/core/catmull_rom_spline_sampler_top.sv */
// Top level of the uniform Catmull-Rom spline sampler: channels, t_step register, response register.
// Depends on crs_pkg, the crs_*_if interfaces, crs_window, crs_datapath and crs_seq.
//
//   channel  | dir | payload                                         | accepted when
//   req_chan | in  | point_x, point_y, restart                       | valid && ready
//   rsp_chan | out | sample_x, sample_y, last_of_segment, saturated  | valid && ready
//   csr_chan | in  | t_step                                          | valid (ready held high)
//
// A restart or filling request only updates the point window. A segment request first
// loads the coefficients, then yields n = ceil(65536 / max(t_step, 1024)) samples, at most 64:
// one shared signed multiplier runs six Horner products per sample plus one output step.
// Reset is synchronous; the point window has no clearing pass.
// A stalled response holds the sequencer at the output step of the next sample.
module catmull_rom_spline_sampler_top (
   input  logic      clock,
   input  logic      reset,
   crs_req_if.sink   req_chan,
   crs_rsp_if.source rsp_chan,
   crs_csr_if.sink   csr_chan
);
   import crs_pkg::*;

   logic                  req_accept;
   logic                  start;
   logic                  full;
   logic                  idle;
   logic                  rsp_free;
   logic                  emit;
   logic                  last;
   logic [STEP_WIDTH-1:0] t;
   logic [STEP_WIDTH-1:0] t_step_ff;
   point_type             point;
   ctl_type               ctl;
   poly_type              poly_x;
   poly_type              poly_y;
   result_type            result;
   logic                  rsp_valid_ff;
   coord_type             rsp_x_ff;
   coord_type             rsp_y_ff;
   logic                  rsp_last_ff;
   logic                  rsp_sat_ff;

   assign req_chan.ready = idle;
   assign req_accept     = req_chan.valid & idle;
   assign start          = req_accept & ~req_chan.restart & full;
   assign point.x        = req_chan.point_x;
   assign point.y        = req_chan.point_y;
   assign csr_chan.ready = 1'b1;
   assign rsp_free       = ~rsp_valid_ff | rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         t_step_ff <= T_STEP_RESET;
      end else if (csr_chan.valid) begin
         t_step_ff <= csr_chan.t_step;
      end
   end

   crs_window u_window (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .point   (point),
      .restart (req_chan.restart),
      .ctl     (ctl),
      .full    (full),
      .poly_x  (poly_x),
      .poly_y  (poly_y)
   );

   crs_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .rsp_free (rsp_free),
      .t_step   (t_step_ff),
      .ctl      (ctl),
      .t        (t),
      .emit     (emit),
      .last     (last),
      .idle     (idle)
   );

   crs_datapath u_datapath (
      .clock  (clock),
      .ctl    (ctl),
      .t      (t),
      .poly_x (poly_x),
      .poly_y (poly_y),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_x_ff    <= result.x;
         rsp_y_ff    <= result.y;
         rsp_last_ff <= last;
         rsp_sat_ff  <= result.sat;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.sample_x        = rsp_x_ff;
   assign rsp_chan.sample_y        = rsp_y_ff;
   assign rsp_chan.last_of_segment = rsp_last_ff;
   assign rsp_chan.saturated       = rsp_sat_ff;

endmodule

/* rtl/core/crs_checker.sv */
// Port-level checks of the spline sampler, attached to the top level by bind.
// Depends on crs_pkg and catmull_rom_spline_sampler_top.
module crs_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last
);
   import crs_pkg::*;

   logic req_accept;
   assign req_accept = req_valid & req_ready;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // no sample can appear the cycle after a request is taken
   a_no_fast_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !$rose(rsp_valid))
      else $error("response too soon after request");

   // a pending mid-segment sample means the segment is still running
   a_busy_mid_seg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("request taken in the middle of a segment");

endmodule

bind catmull_rom_spline_sampler_top crs_checker u_crs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_last  (rsp_chan.last_of_segment)
);
